>>> hw/rtl/iso_mfp_pkg.sv
// ----------------------------------------------------------------------------
// iso_mfp_pkg
// Shared types, codes and field tables for the message field parser.
// ----------------------------------------------------------------------------
package iso_mfp_pkg;

  // Default and maximum number of bitmap fields
  localparam int FIELD_COUNT_DEF = 128;
  localparam int TBL_DEPTH       = 128;
  localparam int TBL_IDX_W       = 7;

  localparam logic [9:0] HEADER_BYTES = 10'd50;
  localparam logic [9:0] BITMAP_PRI   = 10'd8;
  localparam logic [9:0] BITMAP_EXT   = 10'd16;

  // Parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_BITMAP = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  // Byte kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_BITMAP  = 3'd1;
  localparam logic [2:0] KIND_PREFIX  = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;

  // Register map (word index bit of paddr)
  localparam int         ADDR_W  = 3;
  localparam logic       REG_HLC = 1'b0;
  localparam logic [7:0] HLC_RST = 8'd46;

  // Maximum data length per field
  localparam logic [9:0] MAX_LEN [TBL_DEPTH] = '{
    10'd16,  10'd19,  10'd6,   10'd12,  10'd12,  10'd12,  10'd10,  10'd0,
    10'd8,   10'd8,   10'd6,   10'd6,   10'd4,   10'd4,   10'd4,   10'd4,
    10'd0,   10'd4,   10'd3,   10'd0,   10'd0,   10'd3,   10'd3,   10'd0,
    10'd2,   10'd2,   10'd0,   10'd9,   10'd9,   10'd9,   10'd9,   10'd11,
    10'd11,  10'd0,   10'd37,  10'd104, 10'd12,  10'd6,   10'd2,   10'd0,
    10'd8,   10'd15,  10'd40,  10'd25,  10'd76,  10'd0,   10'd0,   10'd512,
    10'd3,   10'd3,   10'd3,   10'd8,   10'd16,  10'd40,  10'd255, 10'd512,
    10'd100, 10'd0,   10'd600, 10'd100, 10'd200, 10'd200, 10'd512, 10'd0,
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd3,   10'd0,   10'd0,
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
    10'd0,   10'd42,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd8,
    10'd0,   10'd0,   10'd0,   10'd11,  10'd0,   10'd28,  10'd28,  10'd512,
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
    10'd512, 10'd0,   10'd0,   10'd512, 10'd256, 10'd0,   10'd0,   10'd0,
    10'd100, 10'd100, 10'd100, 10'd0,   10'd256, 10'd256, 10'd0,   10'd8
  };

  // Number of ASCII length digits per field
  localparam logic [1:0] PREFIX_LEN [TBL_DEPTH] = '{
    2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2,
    2'd2, 2'd0, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3, 2'd3,
    2'd3, 2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd3,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd3, 2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0,
    2'd3, 2'd3, 2'd3, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0
  };

  // One tagged output word
  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] field_number;
    logic [9:0] byte_position;
    logic [7:0] data_byte;
    logic [9:0] field_length;
    logic       last_of_field;
    logic       message_done;
    logic [1:0] error_code;
  } res_t;

endpackage

>>> hw/rtl/iso8583_message_field_parser.sv
// ----------------------------------------------------------------------------
// iso8583_message_field_parser
// Byte-serial field tagger for messages with a 50-byte header, a primary or
// extended bitmap and the present data elements walked in ascending order.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                       | payload
//  --------+-----+---------------------------------+-------------------------------
//  in_     | in  | in_valid / in_ready             | in_byte, in_start_of_message
//  out_    | out | out_valid / out_ready           | kind, field, position, byte,
//          |     |                                 | length, last, done, error
//  apb     | in  | psel / penable / pwrite, pready | paddr, pwdata, prdata
//
//  One word per cycle while in_ready is high: every input word yields one output
//  word, registered as it is accepted. The next-field lookup is a priority
//  encoder over the presence bits, so no field walk stalls the input.
//  A two-entry output (result register plus skid register) lets the input run
//  on while a result waits; in_ready drops only when the skid entry is full.
//  Synchronous reset clears parse state and loads header_length_code with 46.
//
module iso8583_message_field_parser #(
  parameter int FIELD_COUNT = iso_mfp_pkg::FIELD_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_start_of_message,
  // output words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_byte_kind,
  output logic [7:0]                     out_field_number,
  output logic [9:0]                     out_byte_position,
  output logic [7:0]                     out_data_byte,
  output logic [9:0]                     out_field_length,
  output logic                           out_last_of_field,
  output logic                           out_message_done,
  output logic [1:0]                     out_error_code,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iso_mfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import iso_mfp_pkg::*;

  localparam int FIDX_W = $clog2(FIELD_COUNT);

  // parse state
  logic [2:0]             phase_r, phase_nxt;
  logic [9:0]             sc_r, sc_nxt;
  logic [FIELD_COUNT-1:0] pres_r, pres_nxt, pres_upd;
  logic                   ext_r, ext_nxt, ext_cur;
  logic [FIDX_W-1:0]      fld_r, fld_nxt;
  logic [9:0]             left_r, left_nxt;
  logic [1:0]             digits_r, digits_nxt;
  logic [9:0]             pval_r, pval_nxt;
  logic                   frozen_r, frozen_nxt;
  logic [7:0]             hlc_r;

  // output stage
  logic                   out_v_r, skid_v_r;
  res_t                   out_r, skid_r, res;

  logic                   in_acc;
  logic                   enter_req;
  logic [FIDX_W:0]        start_idx;
  logic                   nf_found;
  logic [FIDX_W-1:0]      nf_idx;
  logic [TBL_IDX_W-1:0]   fld_t, nf_t;
  logic                   is_dig;
  logic [9:0]             pv_mul, pv_cur;
  logic [9:0]             bm_len;

  assign in_ready = !skid_v_r;
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // APB register: header length code
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_HLC) ? {24'd0, hlc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlc_r <= HLC_RST;
    end else if (psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_HLC)) begin
      hlc_r <= pwdata[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Bitmap merge: byte k, bit 7-j marks table entry 8k+j
  // --------------------------------------------------------------------------
  always_comb begin
    pres_upd = pres_r;
    if (phase_r == PH_BITMAP) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if ((4'(i >> 3) == sc_r[3:0]) && in_byte[3'(7 - (i % 8))]) begin
          pres_upd[i] = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next field: lowest present entry at or above start_idx that takes bytes
  // --------------------------------------------------------------------------
  assign start_idx = (phase_r == PH_BITMAP) ? (FIDX_W+1)'(1)
                                            : ({1'b0, fld_r} + (FIDX_W+1)'(1));

  always_comb begin
    nf_found = 1'b0;
    nf_idx   = '0;
    for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
      if (pres_upd[i] && ((PREFIX_LEN[i] != 2'd0) || (MAX_LEN[i] != 10'd0)) &&
          ((FIDX_W+1)'(i) >= start_idx)) begin
        nf_found = 1'b1;
        nf_idx   = FIDX_W'(i);
      end
    end
  end

  assign fld_t = TBL_IDX_W'(fld_r);
  assign nf_t  = TBL_IDX_W'(nf_idx);

  // ASCII digit accumulate; low nibble of '0'..'9' is the digit value
  assign is_dig = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign pv_mul = {pval_r[6:0], 3'b000} + {pval_r[8:0], 1'b0} + {6'd0, in_byte[3:0]};
  assign pv_cur = (!frozen_r && is_dig) ? pv_mul : pval_r;

  assign ext_cur = (sc_r == 10'd0) ? in_byte[7] : ext_r;
  assign bm_len  = ext_cur ? BITMAP_EXT : BITMAP_PRI;

  // --------------------------------------------------------------------------
  // Parse step
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    sc_nxt     = sc_r;
    pres_nxt   = pres_r;
    ext_nxt    = ext_r;
    fld_nxt    = fld_r;
    left_nxt   = left_r;
    digits_nxt = digits_r;
    pval_nxt   = pval_r;
    frozen_nxt = frozen_r;
    enter_req  = 1'b0;

    res               = '0;
    res.byte_kind     = KIND_IGNORED;
    res.data_byte     = in_byte;
    res.error_code    = ERR_NONE;

    if (in_start_of_message) begin
      // restart: clear everything, check header byte 0
      sc_nxt     = 10'd0;
      pres_nxt   = '0;
      ext_nxt    = 1'b0;
      fld_nxt    = '0;
      left_nxt   = 10'd0;
      digits_nxt = 2'd0;
      pval_nxt   = 10'd0;
      frozen_nxt = 1'b0;
      if (in_byte != hlc_r) begin
        res.byte_kind  = KIND_ERROR;
        res.error_code = ERR_HEADER;
        phase_nxt      = PH_ERROR;
      end else begin
        res.byte_kind = KIND_HEADER;
        phase_nxt     = PH_HEADER;
        sc_nxt        = 10'd1;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          res.byte_kind     = KIND_HEADER;
          res.byte_position = sc_r;
          if (sc_r + 10'd1 >= HEADER_BYTES) begin
            res.last_of_field = 1'b1;
            phase_nxt         = PH_BITMAP;
            sc_nxt            = 10'd0;
          end else begin
            sc_nxt = sc_r + 10'd1;
          end
        end
        PH_BITMAP: begin
          res.byte_kind     = KIND_BITMAP;
          res.byte_position = sc_r;
          ext_nxt           = ext_cur;
          pres_nxt          = pres_upd;
          if (sc_r + 10'd1 >= bm_len) begin
            res.last_of_field = 1'b1;
            enter_req         = 1'b1;
          end else begin
            sc_nxt = sc_r + 10'd1;
          end
        end
        PH_PREFIX: begin
          res.byte_kind     = KIND_PREFIX;
          res.field_number  = {{(8-FIDX_W){1'b0}}, fld_r} + 8'd1;
          res.byte_position = sc_r;
          pval_nxt          = pv_cur;
          frozen_nxt        = frozen_r || !is_dig;
          sc_nxt            = sc_r + 10'd1;
          digits_nxt        = digits_r - 2'd1;
          if (digits_nxt == 2'd0) begin
            if (pv_cur > MAX_LEN[fld_t]) begin
              res.byte_kind  = KIND_ERROR;
              res.error_code = ERR_LENGTH;
              phase_nxt      = PH_ERROR;
            end else if (pv_cur == 10'd0) begin
              // empty variable field ends on its last prefix byte
              enter_req = 1'b1;
            end else begin
              res.field_length = pv_cur;
              phase_nxt        = PH_DATA;
              left_nxt         = pv_cur;
              sc_nxt           = 10'd0;
            end
          end
        end
        PH_DATA: begin
          res.byte_kind     = KIND_DATA;
          res.field_number  = {{(8-FIDX_W){1'b0}}, fld_r} + 8'd1;
          res.byte_position = sc_r;
          res.field_length  = 10'(sc_r + left_r);
          if (left_r <= 10'd1) begin
            res.last_of_field = 1'b1;
            left_nxt          = 10'd0;
            enter_req         = 1'b1;
          end else begin
            left_nxt = left_r - 10'd1;
            sc_nxt   = sc_r + 10'd1;
          end
        end
        default: begin
          // idle, done, error: byte is ignored
        end
      endcase

      if (enter_req) begin
        if (nf_found) begin
          fld_nxt = nf_idx;
          sc_nxt  = 10'd0;
          if (PREFIX_LEN[nf_t] != 2'd0) begin
            phase_nxt  = PH_PREFIX;
            digits_nxt = PREFIX_LEN[nf_t];
            pval_nxt   = 10'd0;
            frozen_nxt = 1'b0;
          end else begin
            phase_nxt = PH_DATA;
            left_nxt  = MAX_LEN[nf_t];
          end
        end else begin
          phase_nxt        = PH_DONE;
          res.message_done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sc_r     <= 10'd0;
      pres_r   <= '0;
      ext_r    <= 1'b0;
      fld_r    <= '0;
      left_r   <= 10'd0;
      digits_r <= 2'd0;
      pval_r   <= 10'd0;
      frozen_r <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      sc_r     <= sc_nxt;
      pres_r   <= pres_nxt;
      ext_r    <= ext_nxt;
      fld_r    <= fld_nxt;
      left_r   <= left_nxt;
      digits_r <= digits_nxt;
      pval_r   <= pval_nxt;
      frozen_r <= frozen_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid entry
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (out_v_r && !out_ready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (skid_v_r && (out_ready || !out_v_r)) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (out_v_r && !out_ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (skid_v_r && (out_ready || !out_v_r)) begin
      out_r <= skid_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_byte_kind     = out_r.byte_kind;
  assign out_field_number  = out_r.field_number;
  assign out_byte_position = out_r.byte_position;
  assign out_data_byte     = out_r.data_byte;
  assign out_field_length  = out_r.field_length;
  assign out_last_of_field = out_r.last_of_field;
  assign out_message_done  = out_r.message_done;
  assign out_error_code    = out_r.error_code;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_err_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_r.error_code != ERR_NONE) == (out_r.byte_kind == KIND_ERROR)))
    else $error("error code and error kind disagree");

  a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.message_done) |->
      (out_r.last_of_field || (out_r.byte_kind == KIND_PREFIX)))
    else $error("message done away from a field end");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.byte_kind == KIND_DATA)) |->
      ((out_r.field_length != 10'd0) && (out_r.field_number != 8'd0)))
    else $error("data byte without field length or number");

  a_skid_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready && in_acc) |=> skid_v_r)
    else $error("word accepted under stall not kept in skid entry");

endmodule

>>> test/tb_iso8583_message_field_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso8583_message_field_parser
// Streams whole and broken messages through the field parser and checks
// every tagged output word against a cycle-free model of the parse, across
// several header length codes.
// ----------------------------------------------------------------------------
module tb_iso8583_message_field_parser;
  import iso_mfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ADDR_W-1:0] HLC_ADDR = {REG_HLC, 2'b00};

  // one byte waiting to go into the parser
  typedef struct {
    logic [7:0] value;
    logic       sof;
  } msg_byte_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_start_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_byte_kind;
  logic [7:0]  out_field_number;
  logic [9:0]  out_byte_position;
  logic [7:0]  out_data_byte;
  logic [9:0]  out_field_length;
  logic        out_last_of_field;
  logic        out_message_done;
  logic [1:0]  out_error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  iso8583_message_field_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_start_of_message (in_start_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte_kind       (out_byte_kind),
    .out_field_number    (out_field_number),
    .out_byte_position   (out_byte_position),
    .out_data_byte       (out_data_byte),
    .out_field_length    (out_field_length),
    .out_last_of_field   (out_last_of_field),
    .out_message_done    (out_message_done),
    .out_error_code      (out_error_code),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parse model: a private copy of the parser state, advanced once per
  // accepted word.
  // --------------------------------------------------------------------------
  logic [7:0]   hlc_code;
  logic [2:0]   ph;
  logic [9:0]   sec;          // offset inside header / bitmap / prefix / data
  logic [127:0] present;
  logic         ext_bm;
  logic [6:0]   cur;
  logic [9:0]   left;
  logic [1:0]   digits;
  logic [9:0]   pval;
  logic         frozen;

  msg_byte_t    outbound[$];  // words not yet handed to the driver
  res_t         expected_tags[$];
  int           queued;       // message words queued so far (noise excluded)
  int           fail_count;

  function automatic void clear_parse();
    sec     = '0;
    present = '0;
    ext_bm  = 1'b0;
    cur     = '0;
    left    = '0;
    digits  = '0;
    pval    = '0;
    frozen  = 1'b0;
  endfunction

  // Priority search for the next present field that carries bytes; fields
  // with neither prefix nor length are skipped.
  function automatic logic seek_field(input int from);
    logic found;
    found = 1'b0;
    for (int i = from; i < FIELD_COUNT_DEF; i++) begin
      if (!found && present[i] && (PREFIX_LEN[i] != 0 || MAX_LEN[i] != 0)) begin
        found = 1'b1;
        cur   = 7'(i);
        sec   = '0;
        if (PREFIX_LEN[i] != 0) begin
          ph     = PH_PREFIX;
          digits = PREFIX_LEN[i];
          pval   = '0;
          frozen = 1'b0;
        end else begin
          ph   = PH_DATA;
          left = MAX_LEN[i];
        end
      end
    end
    if (!found) ph = PH_DONE;
    return found;
  endfunction

  function automatic res_t tag_byte(input logic [7:0] b, input logic sof);
    res_t r;
    int   f;
    r           = '0;
    r.byte_kind = KIND_IGNORED;
    r.data_byte = b;
    f           = int'(cur);
    if (sof) begin
      // a start always aborts whatever was in flight
      clear_parse();
      ph = PH_HEADER;
      if (b != hlc_code) begin
        r.byte_kind  = KIND_ERROR;
        r.error_code = ERR_HEADER;
        ph           = PH_ERROR;
      end else begin
        r.byte_kind = KIND_HEADER;
        sec         = 10'd1;
      end
    end else begin
      case (ph)
        PH_HEADER: begin
          r.byte_kind     = KIND_HEADER;
          r.byte_position = sec;
          if (sec + 10'd1 >= HEADER_BYTES) begin
            r.last_of_field = 1'b1;
            ph              = PH_BITMAP;
            sec             = '0;
          end else begin
            sec = sec + 10'd1;
          end
        end
        PH_BITMAP: begin
          r.byte_kind     = KIND_BITMAP;
          r.byte_position = sec;
          // bit 7 of the first bitmap byte selects the extended bitmap
          if (sec == 0) ext_bm = b[7];
          for (int j = 0; j < 8; j++)
            if (b[7-j]) present[int'(sec[3:0]) * 8 + j] = 1'b1;
          if (sec + 10'd1 >= (ext_bm ? BITMAP_EXT : BITMAP_PRI)) begin
            r.last_of_field = 1'b1;
            // bit 1 is never a field, so the walk starts at index 1
            if (!seek_field(1)) r.message_done = 1'b1;
          end else begin
            sec = sec + 10'd1;
          end
        end
        PH_PREFIX: begin
          r.byte_kind     = KIND_PREFIX;
          r.field_number  = 8'(f + 1);
          r.byte_position = sec;
          // atoi-style: the first non-digit freezes the value
          if (!frozen && b >= 8'h30 && b <= 8'h39)
            pval = 10'(pval * 10 + (b - 8'h30));
          else
            frozen = 1'b1;
          sec    = sec + 10'd1;
          digits = digits - 2'd1;
          if (digits == 0) begin
            if (pval > MAX_LEN[f]) begin
              r.byte_kind  = KIND_ERROR;
              r.error_code = ERR_LENGTH;
              ph           = PH_ERROR;
            end else if (pval == 0) begin
              // zero length: field ends on its last prefix byte
              if (!seek_field(f + 1)) r.message_done = 1'b1;
            end else begin
              r.field_length = pval;
              ph             = PH_DATA;
              left           = pval;
              sec            = '0;
            end
          end
        end
        PH_DATA: begin
          r.byte_kind     = KIND_DATA;
          r.field_number  = 8'(f + 1);
          r.byte_position = sec;
          r.field_length  = sec + left;
          if (left <= 1) begin
            r.last_of_field = 1'b1;
            left            = '0;
            if (!seek_field(f + 1)) r.message_done = 1'b1;
          end else begin
            left = left - 10'd1;
            sec  = sec + 10'd1;
          end
        end
        default: ;  // idle, done, error: word is ignored
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Message builders: fill the outbound queue without advancing time.
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic sof);
    outbound.push_back('{value: b, sof: sof});
    queued++;
  endtask

  task automatic cut_tail(input int n);
    repeat (n) begin
      void'(outbound.pop_back());
      queued--;
    end
  endtask

  task automatic queue_noise(input int n);
    repeat (n) outbound.push_back('{value: 8'($urandom_range(0, 255)), sof: 1'b0});
  endtask

  task automatic send_header();
    queue_byte(hlc_code, 1'b1);
    repeat (HEADER_BYTES - 1) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // pres[0] is the extension flag, pres[i] field i+1
  task automatic send_bitmap(input logic [127:0] pres);
    logic [7:0] bm;
    for (int k = 0; k < (pres[0] ? 16 : 8); k++) begin
      for (int j = 0; j < 8; j++) bm[7-j] = pres[k*8 + j];
      queue_byte(bm, 1'b0);
    end
  endtask

  // One field at table index idx. want is the length written into the prefix;
  // bad_pos >= 0 swaps that prefix digit for a non-digit. alive drops when the
  // decoded length is over the maximum and the parser stops on an error.
  task automatic send_field(input int idx, input int want, input int bad_pos,
                            output bit alive);
    int         nd;
    int         scale;
    int         v;
    logic       stop;
    logic [7:0] d;
    nd    = PREFIX_LEN[idx];
    scale = (nd == 3) ? 100 : 10;
    v     = 0;
    stop  = 1'b0;
    alive = 1'b1;
    if (nd == 0) begin
      repeat (MAX_LEN[idx]) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    for (int k = 0; k < nd; k++) begin
      d     = 8'(8'h30 + (want / scale) % 10);
      scale = scale / 10;
      if (k == bad_pos) begin
        d = 8'($urandom_range(0, 245));
        if (d >= 8'h30) d = d + 8'd10;
      end
      if (!stop && d >= 8'h30 && d <= 8'h39) v = v * 10 + (d - 8'h30);
      else stop = 1'b1;
      queue_byte(d, 1'b0);
    end
    alive = (v <= MAX_LEN[idx]);
    if (alive) repeat (v) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Mostly short lengths; now and then zero, the maximum or one past it.
  function automatic int pick_length(input int idx);
    int mx;
    int lim;
    int r;
    mx  = MAX_LEN[idx];
    lim = (PREFIX_LEN[idx] == 3) ? 999 : 99;
    r   = $urandom_range(0, 99);
    if (mx == 0) return (r < 70) ? 0 : 1;
    if (r < 8) return 0;
    if (r < 11) return mx;
    if (r < 16 && mx < lim) return mx + 1;
    return $urandom_range(1, (mx < 10) ? mx : 10);
  endfunction

  function automatic logic [127:0] random_presence();
    logic [127:0] p;
    p    = '0;
    p[0] = ($urandom_range(0, 2) != 0);
    for (int i = 1; i < 128; i++) p[i] = ($urandom_range(0, 13) == 0);
    if (!p[0]) p[127:64] = '0;
    return p;
  endfunction

  task automatic send_message(input logic [127:0] pres);
    bit alive;
    int bad;
    alive = 1'b1;
    send_header();
    send_bitmap(pres);
    for (int i = 1; i < (pres[0] ? 128 : 64); i++) begin
      if (alive && pres[i]) begin
        bad = -1;
        if (PREFIX_LEN[i] != 0 && $urandom_range(0, 99) < 6)
          bad = $urandom_range(0, PREFIX_LEN[i] - 1);
        send_field(i, (PREFIX_LEN[i] != 0) ? pick_length(i) : 0, bad, alive);
      end
    end
  endtask

  // Random traffic: mostly well-formed messages, the rest cut-off messages
  // (the next start lands mid-parse), header mismatches and stray words.
  task automatic fill_random(input int target);
    int           first;
    int           mark;
    int           r;
    logic [7:0]   b;
    first = queued;
    while (queued - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 76) begin
        send_message(random_presence());
      end else if (r < 86) begin
        mark = outbound.size();
        send_message(random_presence());
        cut_tail($urandom_range(1, outbound.size() - mark - 1));
      end else if (r < 94) begin
        b = 8'($urandom_range(0, 255));
        if (b == hlc_code) b = ~b;
        queue_byte(b, 1'b1);
        queue_noise($urandom_range(0, 3));
      end else begin
        queue_noise($urandom_range(1, 4));
      end
    end
  endtask

  task automatic send_directed();
    logic [127:0] p;
    bit           alive;
    // stray words before any message, then a header mismatch
    queue_noise(0);
    outbound.push_back('{value: 8'h00, sof: 1'b0});
    outbound.push_back('{value: 8'hFF, sof: 1'b0});
    queue_byte(8'hFF, 1'b1);
    queue_byte(hlc_code, 1'b0);
    // restart mid-header, then a primary bitmap with no fields
    send_header();
    cut_tail(HEADER_BYTES - 4);
    send_message('0);
    // extended bitmap holding only fields that take no bytes
    p = '0;
    p[0] = 1'b1; p[7] = 1'b1; p[16] = 1'b1; p[20] = 1'b1;
    send_message(p);
    // zero-length prefix, fixed field, prefix frozen on its first and on its
    // second digit, 3-digit prefix at the maximum, max-0 field, last field
    p = '0;
    p[0] = 1'b1; p[1] = 1'b1; p[2] = 1'b1; p[32] = 1'b1; p[34] = 1'b1;
    p[35] = 1'b1; p[45] = 1'b1; p[127] = 1'b1;
    send_header();
    send_bitmap(p);
    send_field(1, 0, -1, alive);
    send_field(2, 0, -1, alive);
    send_field(32, 57, 0, alive);
    send_field(34, 12, 1, alive);
    send_field(35, 104, -1, alive);
    send_field(45, 0, -1, alive);
    send_field(127, 0, -1, alive);
    queue_noise(2);  // ignored after done
    // prefix one past the maximum, then a word in the error phase
    p = '0;
    p[1] = 1'b1;
    send_header();
    send_bitmap(p);
    send_field(1, 20, -1, alive);
    queue_noise(1);
  endtask

  // --------------------------------------------------------------------------
  // Random idle gaps: mostly short, a few long, with occasional bursts of no
  // idling at all.
  // --------------------------------------------------------------------------
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      burst = $urandom_range(50, 200);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one word per handshake, model advanced on each accepted word.
  // --------------------------------------------------------------------------
  int        send_gap;
  int        send_burst;
  msg_byte_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_tags.push_back(tag_byte(in_byte, in_start_of_message));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (outbound.size() != 0) begin
          next_word           = outbound.pop_front();
          in_byte             <= next_word.value;
          in_start_of_message <= next_word.sof;
          in_valid            <= 1'b1;
          send_gap            <= pick_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each output word with the oldest expected tag.
  // --------------------------------------------------------------------------
  int   recv_stall;
  int   recv_burst;
  res_t want_tag;

  function automatic void check_field(input string name, input logic [9:0] want,
                                      input logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tags.size() == 0) begin
          $error("output word with no input word behind it");
          fail_count++;
        end else begin
          want_tag = expected_tags.pop_front();
          check_field("byte_kind", 10'(want_tag.byte_kind), 10'(out_byte_kind));
          check_field("field_number", 10'(want_tag.field_number), 10'(out_field_number));
          check_field("byte_position", want_tag.byte_position, out_byte_position);
          check_field("data_byte", 10'(want_tag.data_byte), 10'(out_data_byte));
          check_field("field_length", want_tag.field_length, out_field_length);
          check_field("last_of_field", 10'(want_tag.last_of_field), 10'(out_last_of_field));
          check_field("message_done", 10'(want_tag.message_done), 10'(out_message_done));
          check_field("error_code", 10'(want_tag.error_code), 10'(out_error_code));
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        recv_stall <= pick_gap(recv_burst);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles with work outstanding but no handshake on
  // either channel.
  // --------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (outbound.size() == 0 && expected_tags.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Register access: setup then access phase; the model copy of the code is
  // updated on the write edge, then the register is read back.
  // --------------------------------------------------------------------------
  task automatic program_hlc(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HLC_ADDR;
    pwdata  <= {24'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    hlc_code = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== hlc_code) begin
      $error("header_length_code: expected %0d, actual %0d", hlc_code, prdata[7:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender holds off until every expected word is back; sampled between
  // edges so the driver's last word is already visible on in_valid
  task automatic drain();
    while (outbound.size() != 0 || in_valid || expected_tags.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence: reset-value code with directed messages, then 0, 255, a
  // random code and the reset value again.
  // --------------------------------------------------------------------------
  logic [7:0] code_plan [4];

  initial begin
    fail_count = 0;
    queued     = 0;
    send_burst = 0;
    recv_burst = 0;
    hlc_code   = HLC_RST;
    ph         = PH_IDLE;
    clear_parse();
    code_plan  = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), HLC_RST};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_directed();
    fill_random(180);
    drain();
    foreach (code_plan[i]) begin
      program_hlc(code_plan[i]);
      fill_random((i == 3) ? 100 : 140);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tags.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
